// ===== rtl/dqs_pkg.sv =====
// Package for the DNS query snooper: record codes, parse phases, header
// positions and the fixed-header check. No dependencies.
package dqs_pkg;

   // Header positions, counted from the destination MAC
   localparam int unsigned POS_W = 6;
   localparam logic [POS_W-1:0] POS_ETYPE_HI  = POS_W'(12);
   localparam logic [POS_W-1:0] POS_ETYPE_LO  = POS_W'(13);
   localparam logic [POS_W-1:0] POS_PROTO     = POS_W'(23);
   localparam logic [POS_W-1:0] POS_FLAGS     = POS_W'(44);
   localparam logic [POS_W-1:0] POS_QDCNT_HI  = POS_W'(46);
   localparam logic [POS_W-1:0] POS_QDCNT_LO  = POS_W'(47);
   localparam logic [POS_W-1:0] POS_ANCNT_HI  = POS_W'(48);
   localparam logic [POS_W-1:0] POS_ANCNT_LO  = POS_W'(49);
   localparam logic [POS_W-1:0] POS_NSCNT_HI  = POS_W'(50);
   localparam logic [POS_W-1:0] POS_LAST_CHK  = POS_W'(51);
   localparam logic [POS_W-1:0] POS_LAST_HDR  = POS_W'(53);

   // Expected header values
   localparam logic [7:0] ETH_P_IP_HI   = 8'h08;
   localparam logic [7:0] ETH_P_IP_LO   = 8'h00;
   localparam logic [7:0] UDP_PROTO_NUM = 8'd17;
   localparam logic [7:0] QDCOUNT_LO    = 8'd1;

   typedef enum logic [1:0] {
      REC_NAME = 2'd0,
      REC_DONE = 2'd1,
      REC_DROP = 2'd2
   } rec_kind_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_NAME   = 3'd1,
      PH_GAP    = 3'd2,
      PH_QT_HI  = 3'd3,
      PH_QT_LO  = 3'd4,
      PH_DRAIN  = 3'd5
   } phase_type;

   // One result word
   typedef struct packed {
      rec_kind_type record_kind;
      logic [7:0]   name_byte;
      logic [7:0]   name_length;
      logic [15:0]  query_type;
      logic [2:0]   packet_kind;
   } rec_type;

   // True when the header byte at this position disqualifies the frame
   function automatic logic header_fails(input logic [POS_W-1:0] pos,
                                         input logic [7:0] b);
      logic fail;
      fail = 1'b0;
      unique case (pos)
         POS_ETYPE_HI: fail = (b != ETH_P_IP_HI);
         POS_ETYPE_LO: fail = (b != ETH_P_IP_LO);
         POS_PROTO:    fail = (b != UDP_PROTO_NUM);
         POS_FLAGS:    fail = b[7];
         POS_QDCNT_HI: fail = (b != 8'd0);
         POS_QDCNT_LO: fail = (b != QDCOUNT_LO);
         POS_ANCNT_HI, POS_ANCNT_LO, POS_NSCNT_HI, POS_LAST_CHK:
                       fail = (b != 8'd0);
         default:      fail = 1'b0;
      endcase
      return fail;
   endfunction

endpackage

// ===== rtl/dns_query_snooper_core.sv =====
// Top level of the DNS query snooper: parser plus output skid buffer.
// Depends on dqs_pkg, dqs_parser and dqs_out_buf.
//
// Usage:
//   req_* carries one frame byte per word, starting at the destination MAC,
//   with req_frame_last on the final byte and req_pkt_kind as frame metadata.
//   rsp_* carries records: a name byte (label lengths included) for each
//   QNAME byte of a qualified query, then one completion record with name
//   length, QTYPE and packet kind, or a discard record if the frame ends
//   early after the header checks have passed.
// Timing:
//   One byte accepted per cycle while req_ready is high. A record from a byte
//   is registered into the output stage as that byte is accepted; the parser
//   state updates in that same accept cycle, so there is no per-byte bubble.
//   The output stage is two entries deep: req_ready drops only when both
//   are held by a stalled receiver, and rises again in the cycle after it
//   takes a record. Bytes that cause no record still need req_ready.
// Reset:
//   Synchronous reset empties the output stage and puts the parser in the
//   header phase at byte zero.
module dns_query_snooper_core import dqs_pkg::*; #(
   parameter int unsigned NAME_LIMIT = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_last,
   input  logic [2:0]  req_pkt_kind,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record_kind,
   output logic [7:0]  rsp_name_byte,
   output logic [7:0]  rsp_name_length,
   output logic [15:0] rsp_query_type,
   output logic [2:0]  rsp_packet_kind
);

   logic    step;
   logic    rec_valid;
   rec_type rec;
   rec_type out_rec;

   assign step = req_valid && req_ready;

   dqs_parser #(
      .NAME_LIMIT (NAME_LIMIT)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (req_data_byte),
      .frame_last (req_frame_last),
      .pkt_kind   (req_pkt_kind),
      .rec_valid  (rec_valid),
      .rec        (rec)
   );

   dqs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rec_valid),
      .in_rec    (rec),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_rec   (out_rec),
      .out_ready (rsp_ready)
   );

   // Unpack the record word onto the response ports
   assign rsp_record_kind = out_rec.record_kind;
   assign rsp_name_byte   = out_rec.name_byte;
   assign rsp_name_length = out_rec.name_length;
   assign rsp_query_type  = out_rec.query_type;
   assign rsp_packet_kind = out_rec.packet_kind;

endmodule

// ===== rtl/dqs_parser.sv =====
// Frame parser: header qualification, QNAME walk and QTYPE capture.
// Produces at most one record per accepted word. Depends on dqs_pkg.
module dqs_parser import dqs_pkg::*; #(
   parameter int unsigned NAME_LIMIT = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       frame_last,
   input  logic [2:0] pkt_kind,
   output logic       rec_valid,
   output rec_type    rec
);

   localparam logic [7:0] LimitW = 8'(NAME_LIMIT);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       skip_ff, skip_in;
   logic [7:0]       idx_ff, idx_in;
   logic [7:0]       qhi_ff, qhi_in;
   logic             hdr_fail;

   assign hdr_fail = header_fails(pos_ff, data_byte);

   // Next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      skip_in  = skip_ff;
      idx_in   = idx_ff;
      qhi_in   = qhi_ff;
      if (step) begin
         unique case (phase_ff)
            PH_HEADER: begin
               priority if (hdr_fail) begin
                  phase_in = PH_DRAIN;
               end else if (frame_last) begin
                  phase_in = PH_HEADER;
               end else if (pos_ff >= POS_LAST_HDR) begin
                  phase_in = PH_NAME;
                  skip_in  = 8'd0;
                  idx_in   = 8'd0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            PH_NAME: begin
               priority if (skip_ff != 8'd0) begin
                  skip_in = skip_ff - 8'd1;
                  idx_in  = idx_ff + 8'd1;
               end else if (data_byte == 8'd0) begin
                  phase_in = PH_QT_HI;
               end else begin
                  skip_in = data_byte;
                  idx_in  = idx_ff + 8'd1;
               end
               if (phase_in == PH_NAME && idx_in >= LimitW) begin
                  phase_in = PH_GAP;
               end
            end
            PH_GAP: phase_in = PH_QT_HI;
            PH_QT_HI: begin
               qhi_in   = data_byte;
               phase_in = PH_QT_LO;
            end
            PH_QT_LO: phase_in = PH_DRAIN;
            default:  phase_in = phase_ff;
         endcase
         // Return to the header phase at the end of every frame
         if (frame_last) begin
            phase_in = PH_HEADER;
            pos_in   = '0;
            skip_in  = 8'd0;
            idx_in   = 8'd0;
            qhi_in   = 8'd0;
         end
      end
   end

   // Record generation
   always_comb begin
      rec_valid = 1'b0;
      rec       = '0;
      if (step) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (!hdr_fail && frame_last && pos_ff >= POS_LAST_CHK) begin
                  rec_valid       = 1'b1;
                  rec.record_kind = REC_DROP;
               end
            end
            PH_NAME: begin
               priority if (frame_last) begin
                  rec_valid       = 1'b1;
                  rec.record_kind = REC_DROP;
               end else if (skip_ff != 8'd0 || data_byte != 8'd0) begin
                  rec_valid       = 1'b1;
                  rec.record_kind = REC_NAME;
                  rec.name_byte   = data_byte;
               end else begin
                  rec_valid = 1'b0;
               end
            end
            PH_GAP, PH_QT_HI: begin
               if (frame_last) begin
                  rec_valid       = 1'b1;
                  rec.record_kind = REC_DROP;
               end
            end
            PH_QT_LO: begin
               rec_valid       = 1'b1;
               rec.record_kind = REC_DONE;
               rec.name_length = idx_ff;
               rec.query_type  = {qhi_ff, data_byte};
               rec.packet_kind = pkt_kind;
            end
            default: rec_valid = 1'b0;
         endcase
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         skip_ff  <= 8'd0;
         idx_ff   <= 8'd0;
         qhi_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         idx_ff   <= idx_in;
         qhi_ff   <= qhi_in;
      end
   end

`ifndef SYNTHESIS
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && frame_last) |=> (phase_ff == PH_HEADER && pos_ff == '0))
      else $error("parser did not restart after last word");
   a_idx_capped: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LimitW)
      else $error("name index above limit");
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      (rec_valid && rec.record_kind == REC_DONE) |-> (phase_ff == PH_QT_LO))
      else $error("completion outside QTYPE low phase");
`endif

endmodule

// ===== rtl/dqs_out_buf.sv =====
// Two-entry output register with skid stage for the record channel.
// Depends on dqs_pkg for the record type.
module dqs_out_buf import dqs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rec_type in_rec,
   output logic    in_ready,
   output logic    out_valid,
   output rec_type out_rec,
   input  logic    out_ready
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rec_type main_ff, main_in;
   rec_type skid_ff, skid_in;
   logic    pop;

   assign pop       = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_rec   = main_ff;

   // Advance skid into main when main drains, else park new word in skid
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         main_valid_in = skid_valid_ff || in_valid;
         main_in       = skid_valid_ff ? skid_ff : in_rec;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds a word while main is empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("word pushed into full buffer");
   a_skid_moves: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (main_valid_ff && main_ff == $past(skid_ff)))
      else $error("skid word lost on drain");
`endif

endmodule

// ===== dv/dns_query_snooper_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for dns_query_snooper_core: builds Ethernet frames,
// predicts every name, completion and discard record, and checks them in order.
// Depends on dqs_pkg and the dns_query_snooper_core RTL.
module dns_query_snooper_core_tb;
   import dqs_pkg::*;

   localparam int NAME_MAX    = 255;
   localparam int ITEM_TARGET = 1200;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 8;
   localparam int CUT_RANDOM  = -2;

   // How the records of one frame are checked
   typedef enum logic [1:0] {
      CHK_MODEL = 2'd0,   // predicted per byte
      CHK_QUIET = 2'd1,   // frame must produce nothing
      CHK_DROP  = 2'd2    // frame must end in one discard record
   } chk_mode_type;

   // One frame: spoiled header byte, cut point, name shape, QTYPE, metadata
   typedef struct packed {
      int           bad_pos;   // header byte to spoil, -1 for none
      int           cut_at;    // index of the final byte, -1 natural, CUT_RANDOM
      int           clip;      // bytes removed from the natural end
      int           name_len;  // name bytes to generate, length bytes included
      int           lbl_max;   // longest label
      int           trail;     // bytes after QTYPE
      logic [15:0]  qtype;
      logic [2:0]   pk;
      chk_mode_type chk;
   } frame_spec_type;

   localparam int BAD_SPOTS [10] = '{
      int'(POS_ETYPE_HI), int'(POS_ETYPE_LO), int'(POS_PROTO), int'(POS_FLAGS),
      int'(POS_QDCNT_HI), int'(POS_QDCNT_LO), int'(POS_ANCNT_HI), int'(POS_ANCNT_LO),
      int'(POS_NSCNT_HI), int'(POS_LAST_CHK)
   };

   // bad_pos, cut_at, clip, name_len, lbl_max, trail, qtype, pk, chk
   localparam frame_spec_type DIR_ROWS [15] = '{
      '{-1, 0, 0, 8, 8, 0, 16'h0001, 3'd0, CHK_QUIET},                  // lone byte
      '{int'(POS_ETYPE_HI), int'(POS_ETYPE_HI), 0, 0, 1, 0, 16'h0001, 3'd1,
        CHK_QUIET},                                                     // ends on bad byte
      '{int'(POS_PROTO), int'(POS_PROTO), 0, 0, 1, 0, 16'h0001, 3'd1, CHK_QUIET},
      '{int'(POS_FLAGS), -1, 0, 0, 1, 0, 16'h0001, 3'd1, CHK_QUIET},     // response
      '{int'(POS_QDCNT_LO), int'(POS_QDCNT_LO), 0, 0, 1, 0, 16'h0001, 3'd1,
        CHK_QUIET},
      '{int'(POS_LAST_CHK), int'(POS_LAST_CHK), 0, 0, 1, 0, 16'h0001, 3'd1,
        CHK_QUIET},
      '{-1, 50, 0, 0, 1, 0, 16'h0001, 3'd2, CHK_QUIET},                 // ends unchecked
      '{-1, int'(POS_LAST_CHK), 0, 0, 1, 0, 16'h0001, 3'd2, CHK_DROP},
      '{-1, int'(POS_LAST_HDR), 0, 0, 1, 0, 16'h0001, 3'd2, CHK_DROP},
      '{-1, -1, 0, 0, 1, 1, 16'hFFFF, 3'd7, CHK_MODEL},                 // root name
      '{-1, 311, 0, 300, 63, 0, 16'h001C, 3'd3, CHK_MODEL},             // over limit
      '{-1, -1, 1, 4, 3, 0, 16'h0005, 3'd5, CHK_MODEL},                 // ends on QTYPE hi
      '{-1, -1, 2, 4, 3, 0, 16'h0005, 3'd6, CHK_MODEL},                 // ends on terminator
      '{-1, 60, 0, 30, 10, 0, 16'h0005, 3'd1, CHK_MODEL},               // ends inside name
      '{-1, 54, 0, 30, 10, 0, 16'h0005, 3'd3, CHK_MODEL}                // ends on first name byte
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_frame_last;
   logic [2:0]  req_pkt_kind;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_record_kind;
   logic [7:0]  rsp_name_byte;
   logic [7:0]  rsp_name_length;
   logic [15:0] rsp_query_type;
   logic [2:0]  rsp_packet_kind;

   // Predictor state for the frame in flight
   logic [8:0]  hdr_pos;
   phase_type   phase;
   logic [7:0]  label_left;
   logic [7:0]  name_count;
   logic [7:0]  qt_hi;

   rec_type     want_recs [$];
   bit          calm;
   int          err_count;
   int          frames_sent;
   int          bytes_sent;
   int          kind_seen [3];
   int          cycles;

   dns_query_snooper_core #(.NAME_LIMIT(NAME_MAX)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_frame_last  (req_frame_last),
      .req_pkt_kind    (req_pkt_kind),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_record_kind (rsp_record_kind),
      .rsp_name_byte   (rsp_name_byte),
      .rsp_name_length (rsp_name_length),
      .rsp_query_type  (rsp_query_type),
      .rsp_packet_kind (rsp_packet_kind)
   );

   always #6 clock = ~clock;

   function automatic rec_type make_rec(input rec_kind_type k, input logic [7:0] nb,
                                        input logic [7:0] nl, input logic [15:0] qt,
                                        input logic [2:0] pk);
      rec_type r;
      r.record_kind = k;
      r.name_byte   = nb;
      r.name_length = nl;
      r.query_type  = qt;
      r.packet_kind = pk;
      return r;
   endfunction

   // Required value and compared bits of one header byte; mask 0 means unchecked
   function automatic void hdr_rule(input int pos, output logic [7:0] want,
                                    output logic [7:0] mask);
      want = 8'h00;
      mask = 8'hFF;
      case (pos)
         POS_ETYPE_HI: want = ETH_P_IP_HI;
         POS_ETYPE_LO: want = ETH_P_IP_LO;
         POS_PROTO:    want = UDP_PROTO_NUM;
         POS_FLAGS:    mask = 8'h80;
         POS_QDCNT_LO: want = QDCOUNT_LO;
         POS_QDCNT_HI, POS_ANCNT_HI, POS_ANCNT_LO, POS_NSCNT_HI, POS_LAST_CHK: ;
         default:      mask = 8'h00;
      endcase
   endfunction

   function automatic void restart_frame();
      hdr_pos    = '0;
      phase      = PH_HEADER;
      label_left = '0;
      name_count = '0;
      qt_hi      = '0;
   endfunction

   // Advance the parser by one frame byte; return 1 with the record it emits
   function automatic bit snoop_step(input logic [7:0] b, input logic last,
                                     input logic [2:0] pk, output rec_type rec);
      logic [7:0] want;
      logic [7:0] mask;
      bit         hit;
      hit = 1'b0;
      rec = make_rec(REC_NAME, 8'd0, 8'd0, 16'd0, 3'd0);
      case (phase)
         PH_HEADER: begin
            hdr_rule(int'(hdr_pos), want, mask);
            if (((b ^ want) & mask) != 8'd0) begin
               phase = PH_DRAIN;
            end else if (last) begin
               if (hdr_pos >= POS_LAST_CHK) begin
                  hit = 1'b1;
                  rec = make_rec(REC_DROP, 8'd0, 8'd0, 16'd0, 3'd0);
               end
            end else if (hdr_pos >= POS_LAST_HDR) begin
               phase      = PH_NAME;
               label_left = '0;
               name_count = '0;
            end else begin
               hdr_pos = hdr_pos + 9'd1;
            end
         end
         PH_NAME: begin
            if (label_left != 8'd0 || b != 8'd0) begin
               label_left = (label_left != 8'd0) ? label_left - 8'd1 : b;
               hit        = 1'b1;
               rec        = make_rec(REC_NAME, b, 8'd0, 16'd0, 3'd0);
               name_count = name_count + 8'd1;
            end else begin
               phase = PH_QT_HI;
            end
            // cap the name: pass over one byte, then QTYPE
            if (phase == PH_NAME && int'(name_count) >= NAME_MAX)
               phase = PH_GAP;
            if (last) begin
               hit = 1'b1;
               rec = make_rec(REC_DROP, 8'd0, 8'd0, 16'd0, 3'd0);
            end
         end
         PH_GAP, PH_QT_HI: begin
            if (phase == PH_QT_HI)
               qt_hi = b;
            phase = (phase == PH_GAP) ? PH_QT_HI : PH_QT_LO;
            if (last) begin
               hit = 1'b1;
               rec = make_rec(REC_DROP, 8'd0, 8'd0, 16'd0, 3'd0);
            end
         end
         PH_QT_LO: begin
            hit   = 1'b1;
            rec   = make_rec(REC_DONE, 8'd0, name_count, {qt_hi, b}, pk);
            phase = PH_DRAIN;
         end
         default: ;
      endcase
      if (last)
         restart_frame();
      return hit;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (calm || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(3, 1);
      if (r < 98)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Build one frame from its spec, send it byte by byte and queue its records
   task automatic send_frame(input frame_spec_type s);
      logic [7:0] fb [$];
      logic [7:0] want;
      logic [7:0] mask;
      logic [7:0] flip;
      rec_type    rec;
      bit         hit;
      int         total;
      int         lbl;
      int         last_idx;
      int         gap;
      for (int pos = 0; pos <= int'(POS_LAST_HDR); pos++) begin
         hdr_rule(pos, want, mask);
         fb.push_back(8'(($urandom_range(255, 0) & ~mask) | (want & mask)));
      end
      if (s.bad_pos >= 0) begin
         hdr_rule(s.bad_pos, want, mask);
         do flip = 8'($urandom_range(255, 1)) & mask; while (flip == 8'd0);
         fb[s.bad_pos] = fb[s.bad_pos] ^ flip;
      end
      // labels with random content, then terminator, QTYPE and trailing bytes
      total = 0;
      while (total < s.name_len) begin
         lbl = $urandom_range(s.lbl_max, 1);
         fb.push_back(8'(lbl));
         repeat (lbl) fb.push_back(8'($urandom));
         total += lbl + 1;
      end
      fb.push_back(8'h00);
      fb.push_back(s.qtype[15:8]);
      fb.push_back(s.qtype[7:0]);
      repeat (s.trail) fb.push_back(8'($urandom));
      last_idx = fb.size() - 1 - s.clip;
      if (s.cut_at == CUT_RANDOM)
         last_idx = $urandom_range(last_idx, int'(POS_FLAGS));
      else if (s.cut_at >= 0)
         last_idx = s.cut_at;

      for (int i = 0; i <= last_idx; i++) begin
         gap = pick_gap();
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         req_valid      <= 1'b1;
         req_data_byte  <= fb[i];
         req_frame_last <= (i == last_idx);
         req_pkt_kind   <= s.pk;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         hit = snoop_step(fb[i], i == last_idx, s.pk, rec);
         case (s.chk)
            CHK_MODEL: if (hit) want_recs.push_back(rec);
            CHK_DROP:  if (i == last_idx)
                          want_recs.push_back(make_rec(REC_DROP, 8'd0, 8'd0, 16'd0, 3'd0));
            default:   ;
         endcase
      end
      frames_sent++;
      bytes_sent += last_idx + 1;
   endtask

   // Drop valid and hold the sender until every queued record has come
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (want_recs.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls on rsp_ready
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0 && !calm) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // Check each accepted record against the oldest expectation
   always @(posedge clock) begin : rec_check
      rec_type got;
      rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = make_rec(rec_kind_type'(rsp_record_kind), rsp_name_byte, rsp_name_length,
                        rsp_query_type, rsp_packet_kind);
         if (int'(got.record_kind) < 3)
            kind_seen[int'(got.record_kind)]++;
         if (want_recs.size() == 0) begin
            err_count++;
            $display("%0t ns: unexpected record, kind %0d byte %h len %0d qtype %h pkt %0d",
                     $time, got.record_kind, got.name_byte, got.name_length,
                     got.query_type, got.packet_kind);
         end else begin
            want = want_recs.pop_front();
            if (got !== want) begin
               err_count++;
               $display("%0t ns: record mismatch, expected kind %0d byte %h len %0d %s",
                        $time, want.record_kind, want.name_byte, want.name_length,
                        $sformatf("qtype %h pkt %0d", want.query_type, want.packet_kind));
               $display("%0t ns:                 got kind %0d byte %h len %0d %s",
                        $time, got.record_kind, got.name_byte, got.name_length,
                        $sformatf("qtype %h pkt %0d", got.query_type, got.packet_kind));
            end
         end
      end
   end

   // Watchdog: end the run at a generous cycle limit
   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
         @(posedge clock);
      $display("%0t ns: timeout after %0d cycles, %0d records still expected",
               $time, CYCLE_LIMIT, want_recs.size());
      $display("dns_query_snooper_core_tb: done, errors");
      $finish;
   end

   // Stimulus: directed frames, then random frames up to the byte budget
   initial begin
      frame_spec_type s;
      int             r;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = 8'd0;
      req_frame_last = 1'b0;
      req_pkt_kind   = 3'd0;
      calm           = 1'b0;
      err_count      = 0;
      frames_sent    = 0;
      bytes_sent     = 0;
      kind_seen      = '{0, 0, 0};
      restart_frame();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIR_ROWS); i++)
         send_frame(DIR_ROWS[i]);
      hold_until_drained();

      // mostly well-formed queries, some spoiled, cut or short noise frames
      while (bytes_sent < ITEM_TARGET) begin
         calm = ($urandom_range(5, 0) == 0);
         s = '{bad_pos: -1, cut_at: -1, clip: 0, name_len: $urandom_range(24, 0),
               lbl_max: $urandom_range(15, 1), trail: 0, qtype: 16'($urandom),
               pk: 3'($urandom), chk: CHK_MODEL};
         r = $urandom_range(99, 0);
         if (r < 8)
            s.cut_at = $urandom_range(11, 0);
         else if (r < 20)
            s.bad_pos = BAD_SPOTS[$urandom_range(9, 0)];
         else if (r < 32)
            s.cut_at = CUT_RANDOM;
         else if (r < 36) begin
            s.name_len = $urandom_range(40, 24);
            s.lbl_max  = $urandom_range(63, 16);
         end else if (r < 55)
            s.trail = $urandom_range(6, 1);
         send_frame(s);
         if (frames_sent == $size(DIR_ROWS) + 2)
            hold_until_drained();
      end
      calm = 1'b0;

      // drain, then let trailing records surface
      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d frames (%0d bytes): header rejects, early ends, capped names.",
               frames_sent, bytes_sent);
      $display("Checked %0d name-byte, %0d completion and %0d discard records, %0d errors.",
               kind_seen[0], kind_seen[1], kind_seen[2], err_count);
      if (err_count == 0)
         $display("dns_query_snooper_core_tb: done, clean");
      else
         $display("dns_query_snooper_core_tb: done, errors");
      $finish;
   end

endmodule
